// ===== rtl/lfps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared widths, register codes, microcode types and arithmetic helpers for
// the line follower PID steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

   localparam int SENSOR_COUNT   = 5;
   localparam int SAMPLE_BITS    = 10;
   localparam int GAIN_BITS      = 24;
   localparam int SPEED_BITS     = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int ERR_BITS       = 16;
   localparam int SUM_BITS       = 32;
   localparam int DERIV_BITS     = ERR_BITS + 1;
   localparam int POS_BITS       = 5;
   localparam int COUNT_BITS     = 3;
   localparam int MAG_BITS       = 4;
   localparam int QUOT_BITS      = ERR_BITS - 1;
   localparam int OPND_BITS      = 32;
   localparam int PROD_BITS      = GAIN_BITS + 1 + OPND_BITS;
   localparam int ACC_BITS       = PROD_BITS + 1;
   localparam int FRAC_BITS      = 28;
   localparam int STEP_BITS      = 3;

   localparam logic signed [ERR_BITS-1:0] ERR_LOST   = 16'sd10240;
   localparam logic [SPEED_BITS-1:0]      SPEED_MAX  = 8'd255;

   localparam logic [GAIN_BITS-1:0]   PROP_GAIN_RESET      = 24'd3932160;
   localparam logic [GAIN_BITS-1:0]   INTEG_GAIN_RESET     = 24'd328;
   localparam logic [GAIN_BITS-1:0]   DERIV_GAIN_RESET     = 24'd655360;
   localparam logic [SPEED_BITS-1:0]  BASE_SPEED_RESET     = 8'd150;
   localparam logic [SAMPLE_BITS-1:0] DARK_THRESHOLD_RESET = 10'd300;

   // sensor weights in half units, far left to far right
   localparam logic signed [POS_BITS-1:0] HALF_WEIGHT [SENSOR_COUNT] =
      '{5'sd5, 5'sd3, 5'sd0, -5'sd3, -5'sd5};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_INTEG_GAIN     = 3'd1,
      CSR_DERIV_GAIN     = 3'd2,
      CSR_BASE_SPEED     = 3'd3,
      CSR_DARK_THRESHOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]   prop_gain;
      logic [GAIN_BITS-1:0]   integ_gain;
      logic [GAIN_BITS-1:0]   deriv_gain;
      logic [SPEED_BITS-1:0]  base_speed;
      logic [SAMPLE_BITS-1:0] dark_threshold;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_INTEG,
      OP_MUL_I,
      OP_MUL_D,
      OP_ACC,
      OP_LEFT,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_WAIT_IN,
      JC_WAIT_OUT
   } jump_type;

   typedef struct packed {
      op_type                op;
      jump_type              jump;
      logic [STEP_BITS-1:0]  target;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   fire;
      logic   in_ready;
   } ctl_type;

   // floor(m * 2048 / 3)
   function automatic logic [QUOT_BITS-1:0] third_of(input logic [MAG_BITS-1:0] mag);
      logic [QUOT_BITS-1:0] q;
      case (mag)
         4'd1:    q = 15'd682;
         4'd2:    q = 15'd1365;
         4'd3:    q = 15'd2048;
         4'd4:    q = 15'd2730;
         4'd5:    q = 15'd3413;
         4'd6:    q = 15'd4096;
         4'd7:    q = 15'd4778;
         4'd8:    q = 15'd5461;
         default: q = '0;
      endcase
      return q;
   endfunction

   // floor(m * 2048 / 5)
   function automatic logic [QUOT_BITS-1:0] fifth_of(input logic [MAG_BITS-1:0] mag);
      logic [QUOT_BITS-1:0] q;
      case (mag)
         4'd1:    q = 15'd409;
         4'd2:    q = 15'd819;
         4'd3:    q = 15'd1228;
         4'd4:    q = 15'd1638;
         4'd5:    q = 15'd2048;
         4'd6:    q = 15'd2457;
         4'd7:    q = 15'd2867;
         4'd8:    q = 15'd3276;
         default: q = '0;
      endcase
      return q;
   endfunction

   // mean half weight in q.11, truncated toward zero
   function automatic logic signed [ERR_BITS-1:0] err_of(
      input logic signed [POS_BITS-1:0] pos,
      input logic [COUNT_BITS-1:0]      count
   );
      logic [MAG_BITS-1:0]   mag;
      logic [QUOT_BITS-1:0]  q;
      logic signed [ERR_BITS-1:0] e;
      mag = pos[POS_BITS-1] ? MAG_BITS'(-pos) : MAG_BITS'(pos);
      case (count)
         3'd1:    q = {mag, 11'd0};
         3'd2:    q = {1'b0, mag, 10'd0};
         3'd3:    q = third_of(mag);
         3'd4:    q = {2'b0, mag, 9'd0};
         3'd5:    q = fifth_of(mag);
         default: q = '0;
      endcase
      e = $signed({1'b0, q});
      return pos[POS_BITS-1] ? -e : e;
   endfunction

   // drive level from a q.28 total, clamped to 0..255
   function automatic logic [SPEED_BITS-1:0] speed_of(
      input logic signed [ACC_BITS-1:0] total
   );
      logic [SPEED_BITS-1:0] s;
      if (total[ACC_BITS-1]) begin
         s = '0;
      end else if (|total[ACC_BITS-2:FRAC_BITS+SPEED_BITS]) begin
         s = SPEED_MAX;
      end else begin
         s = total[FRAC_BITS+SPEED_BITS-1:FRAC_BITS];
      end
      return s;
   endfunction

endpackage

// ===== rtl/lfps_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_sequencer
// Step counter and microcode rom; issues one control word per step, with
// waits on the input and output channels and a jump back to the load step.
// ----------------------------------------------------------------------------
module lfps_sequencer
   import lfps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    out_busy,
   output ctl_type ctl
);

   localparam logic [STEP_BITS-1:0] STEP_LOAD  = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_INTEG = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_MUL_I = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_MUL_D = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_ACC   = 3'd4;
   localparam logic [STEP_BITS-1:0] STEP_LEFT  = 3'd5;
   localparam logic [STEP_BITS-1:0] STEP_OUT   = 3'd6;

   logic [STEP_BITS-1:0] step_ff;
   logic [STEP_BITS-1:0] step_in;
   ucode_type            word;
   logic                 fire;

   // microprogram
   always_comb begin
      unique case (step_ff)
         STEP_LOAD:  word = '{op: OP_LOAD,  jump: JC_WAIT_IN,  target: STEP_INTEG};
         STEP_INTEG: word = '{op: OP_INTEG, jump: JC_NEXT,     target: STEP_MUL_I};
         STEP_MUL_I: word = '{op: OP_MUL_I, jump: JC_NEXT,     target: STEP_MUL_D};
         STEP_MUL_D: word = '{op: OP_MUL_D, jump: JC_NEXT,     target: STEP_ACC};
         STEP_ACC:   word = '{op: OP_ACC,   jump: JC_NEXT,     target: STEP_LEFT};
         STEP_LEFT:  word = '{op: OP_LEFT,  jump: JC_NEXT,     target: STEP_OUT};
         STEP_OUT:   word = '{op: OP_OUT,   jump: JC_WAIT_OUT, target: STEP_LOAD};
         default:    word = '{op: OP_LEFT,  jump: JC_WAIT_OUT, target: STEP_LOAD};
      endcase
   end

   always_comb begin
      unique case (word.jump)
         JC_WAIT_IN: begin
            fire    = req_valid;
            step_in = req_valid ? step_ff + 1'b1 : step_ff;
         end
         JC_WAIT_OUT: begin
            fire    = !out_busy;
            step_in = out_busy ? step_ff : word.target;
         end
         default: begin
            fire    = 1'b1;
            step_in = step_ff + 1'b1;
         end
      endcase
   end

   assign ctl.op       = word.op;
   assign ctl.fire     = fire;
   assign ctl.in_ready = (word.jump == JC_WAIT_IN);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/lfps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_datapath
// Sensor classification, error table, saturating integral, one shared
// 25x32 multiplier with accumulator, speed clamp and the result register.
// ----------------------------------------------------------------------------
module lfps_datapath
   import lfps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_type                ctl,
   input  cfg_type                cfg,
   input  logic [SAMPLE_BITS-1:0] samples [SENSOR_COUNT],
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [SPEED_BITS-1:0]  rsp_left_speed,
   output logic [SPEED_BITS-1:0]  rsp_right_speed,
   output logic                   rsp_line_lost,
   output logic                   out_busy
);

   logic signed [POS_BITS-1:0]   pos;
   logic [COUNT_BITS-1:0]        count;
   logic                         lost;
   logic signed [ERR_BITS-1:0]   load_err;
   logic [GAIN_BITS-1:0]         mul_gain;
   logic signed [OPND_BITS-1:0]  mul_opnd;
   logic signed [PROD_BITS-1:0]  product;
   logic signed [SUM_BITS:0]     sum_wide;
   logic signed [SUM_BITS-1:0]   sum_sat;
   logic signed [ACC_BITS-1:0]   base_q;
   logic signed [ACC_BITS-1:0]   acc_next;

   logic signed [ERR_BITS-1:0]   err_ff,        err_in;
   logic                         lost_ff,       lost_in;
   logic signed [ERR_BITS-1:0]   last_error_ff, last_error_in;
   logic signed [SUM_BITS-1:0]   error_sum_ff,  error_sum_in;
   logic signed [DERIV_BITS-1:0] deriv_ff,      deriv_in;
   logic signed [PROD_BITS-1:0]  prod_ff,       prod_in;
   logic signed [ACC_BITS-1:0]   acc_ff,        acc_in;
   logic [SPEED_BITS-1:0]        left_ff,       left_in;
   logic                         rsp_valid_ff,  rsp_valid_in;
   logic [SPEED_BITS-1:0]        rsp_left_ff,   rsp_left_in;
   logic [SPEED_BITS-1:0]        rsp_right_ff,  rsp_right_in;
   logic                         rsp_lost_ff,   rsp_lost_in;

   // dark sensors
   always_comb begin
      pos   = '0;
      count = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (samples[i] >= cfg.dark_threshold) begin
            pos   = pos + HALF_WEIGHT[i];
            count = count + 1'b1;
         end
      end
   end

   assign lost = (count == '0);

   always_comb begin
      if (!lost) begin
         load_err = err_of(pos, count);
      end else if (!last_error_ff[ERR_BITS-1] && (last_error_ff != '0)) begin
         load_err = ERR_LOST;
      end else begin
         load_err = -ERR_LOST;
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (ctl.op)
         OP_MUL_I: begin
            mul_gain = cfg.integ_gain;
            mul_opnd = error_sum_ff;
         end
         OP_MUL_D: begin
            mul_gain = cfg.deriv_gain;
            mul_opnd = OPND_BITS'(deriv_ff);
         end
         default: begin
            mul_gain = cfg.prop_gain;
            mul_opnd = OPND_BITS'(err_ff);
         end
      endcase
   end

   assign product  = $signed({1'b0, mul_gain}) * mul_opnd;
   assign acc_next = acc_ff + ACC_BITS'(prod_ff);

   // saturating integral
   assign sum_wide = (SUM_BITS+1)'(error_sum_ff) + (SUM_BITS+1)'(err_ff);
   always_comb begin
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                      : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_BITS-1:0];
      end
   end

   assign base_q = $signed({{(ACC_BITS-SPEED_BITS-FRAC_BITS){1'b0}},
                            cfg.base_speed, {FRAC_BITS{1'b0}}});

   always_comb begin
      err_in        = err_ff;
      lost_in       = lost_ff;
      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      deriv_in      = deriv_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_lost_in   = rsp_lost_ff;
      if (ctl.fire) begin
         unique case (ctl.op)
            OP_LOAD: begin
               err_in  = load_err;
               lost_in = lost;
               acc_in  = '0;
            end
            OP_INTEG: begin
               error_sum_in  = sum_sat;
               deriv_in      = DERIV_BITS'(err_ff) - DERIV_BITS'(last_error_ff);
               last_error_in = err_ff;
               prod_in       = product;
            end
            OP_MUL_I, OP_MUL_D: begin
               prod_in = product;
               acc_in  = acc_next;
            end
            OP_ACC: begin
               acc_in = acc_next;
            end
            OP_LEFT: begin
               left_in = speed_of(base_q + acc_ff);
            end
            OP_OUT: begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_ff;
               rsp_right_in = speed_of(base_q - acc_ff);
               rsp_lost_in  = lost_ff;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      err_ff       <= err_in;
      lost_ff      <= lost_in;
      deriv_ff     <= deriv_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      left_ff      <= left_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_lost_ff  <= rsp_lost_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = rsp_left_ff;
   assign rsp_right_speed = rsp_right_ff;
   assign rsp_line_lost   = rsp_lost_ff;
   assign out_busy        = rsp_valid_ff & rsp_stall;

endmodule

// ===== rtl/line_follower_pid_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_pid_steering
// PID steering for a five-sensor line follower: each item of five samples
// yields left and right drive levels and a line lost flag. A seven-step
// microprogram runs over one shared 25x32 multiplier: an item is taken at
// the load step and its result is registered at the output step, after
// which the next item can be taken. The result register lets the next
// item be taken while a result still waits; the final step holds only
// while the previous result is still unclaimed. csr_ready is always high;
// writes to indexes above four are ignored.
// ----------------------------------------------------------------------------
module line_follower_pid_steering
   import lfps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_sample_far_left,
   input  logic [SAMPLE_BITS-1:0]    req_sample_near_left,
   input  logic [SAMPLE_BITS-1:0]    req_sample_center,
   input  logic [SAMPLE_BITS-1:0]    req_sample_near_right,
   input  logic [SAMPLE_BITS-1:0]    req_sample_far_right,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SPEED_BITS-1:0]     rsp_left_speed,
   output logic [SPEED_BITS-1:0]     rsp_right_speed,
   output logic                      rsp_line_lost,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [GAIN_BITS-1:0]      csr_wdata
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   ctl_type                ctl;
   logic                   out_busy;
   logic [SAMPLE_BITS-1:0] samples [SENSOR_COUNT];

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:      cfg_in.prop_gain      = csr_wdata;
            CSR_INTEG_GAIN:     cfg_in.integ_gain     = csr_wdata;
            CSR_DERIV_GAIN:     cfg_in.deriv_gain     = csr_wdata;
            CSR_BASE_SPEED:     cfg_in.base_speed     = csr_wdata[SPEED_BITS-1:0];
            CSR_DARK_THRESHOLD: cfg_in.dark_threshold = csr_wdata[SAMPLE_BITS-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= PROP_GAIN_RESET;
         cfg_ff.integ_gain     <= INTEG_GAIN_RESET;
         cfg_ff.deriv_gain     <= DERIV_GAIN_RESET;
         cfg_ff.base_speed     <= BASE_SPEED_RESET;
         cfg_ff.dark_threshold <= DARK_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign samples[0] = req_sample_far_left;
   assign samples[1] = req_sample_near_left;
   assign samples[2] = req_sample_center;
   assign samples[3] = req_sample_near_right;
   assign samples[4] = req_sample_far_right;

   assign req_stall = !ctl.in_ready;

   lfps_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .ctl       (ctl)
   );

   lfps_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .cfg             (cfg_ff),
      .samples         (samples),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_line_lost   (rsp_line_lost),
      .out_busy        (out_busy)
   );

`ifndef SYNTHESIS
   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken while another is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && ctl.op == OP_OUT) |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   a_rsp_from_out_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl.fire && ctl.op == OP_OUT))
      else $error("result shown without an output step");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_follower_pid_steering. A queue of sensor scans
// feeds a bursty sender; a stalling receiver checks every steering result
// against a predictor of the position error, the clamped integral and the
// PID drive levels. The run steps through several register settings, its
// extremes among them.
// ----------------------------------------------------------------------------
module tb;
   import lfps_pkg::*;

   typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] scan_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] left;
      logic [SPEED_BITS-1:0] right;
      logic                  lost;
   } steer_type;

   typedef enum {FLOW_FREE, FLOW_COIN, FLOW_CHOKED, FLOW_PERIODIC} flow_type;

   localparam int     WEIGHT_HALVES [SENSOR_COUNT] = '{5, 3, 0, -3, -5};
   localparam int     LOST_ERR      = 10240;
   localparam int     Q_SHIFT       = 28;
   localparam int     SAMPLE_TOP    = (1 << SAMPLE_BITS) - 1;
   localparam longint INT_TOP       = 64'sd2147483647;
   localparam longint INT_BOTTOM    = -64'sd2147483648;
   localparam int     PHASE_COUNT   = 8;
   localparam int     ITEMS_PER_SET = 200;
   localparam int     TAIL_ITEMS    = 40;
   localparam int     SETTLE        = 16;
   localparam int     LONG_HOLD     = 400;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_sample_far_left = '0;
   logic [SAMPLE_BITS-1:0]    req_sample_near_left = '0;
   logic [SAMPLE_BITS-1:0]    req_sample_center = '0;
   logic [SAMPLE_BITS-1:0]    req_sample_near_right = '0;
   logic [SAMPLE_BITS-1:0]    req_sample_far_right = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SPEED_BITS-1:0]     rsp_left_speed;
   logic [SPEED_BITS-1:0]     rsp_right_speed;
   logic                      rsp_line_lost;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [GAIN_BITS-1:0]      csr_wdata = '0;

   line_follower_pid_steering dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample_far_left   (req_sample_far_left),
      .req_sample_near_left  (req_sample_near_left),
      .req_sample_center     (req_sample_center),
      .req_sample_near_right (req_sample_near_right),
      .req_sample_far_right  (req_sample_far_right),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_left_speed        (rsp_left_speed),
      .rsp_right_speed       (rsp_right_speed),
      .rsp_line_lost         (rsp_line_lost),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // steering model: registers and loop state
   longint prop_k;
   longint integ_k;
   longint deriv_k;
   longint base_lvl;
   int     dark_level;
   int     err_prev;
   int     err_sum;

   scan_type  pending [$];
   steer_type steer_expect [$];
   scan_type  held_scan;

   int     items_sent = 0;
   int     results_checked = 0;
   int     settings_used = 0;
   int     sat_hits = 0;
   int     bad = 0;

   int       burst_left = 1;
   int       gap_left = 0;
   int       rsp_cycle = 0;
   int       hold_left = 0;
   bit       held_once = 1'b0;
   flow_type stall_mode = FLOW_FREE;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void cfg_apply(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [GAIN_BITS-1:0] val);
      case (idx)
         CSR_PROP_GAIN:      prop_k = longint'(val);
         CSR_INTEG_GAIN:     integ_k = longint'(val);
         CSR_DERIV_GAIN:     deriv_k = longint'(val);
         CSR_BASE_SPEED:     base_lvl = longint'(val[SPEED_BITS-1:0]);
         CSR_DARK_THRESHOLD: dark_level = int'(val[SAMPLE_BITS-1:0]);
         default: ;
      endcase
   endfunction

   function automatic logic [SPEED_BITS-1:0] drive_level(input longint total);
      longint whole;
      if (total < 0) return '0;
      whole = total >>> Q_SHIFT;
      return (whole > 255) ? SPEED_BITS'(255) : SPEED_BITS'(whole);
   endfunction

   function automatic steer_type predict_steer(input scan_type scan);
      int        pos;
      int        cnt;
      int        err;
      int        k;
      longint    sum;
      longint    corr;
      longint    base;
      steer_type r;
      pos = 0;
      cnt = 0;
      for (k = 0; k < SENSOR_COUNT; k++) begin
         if (int'(scan[k]) >= dark_level) begin
            pos += WEIGHT_HALVES[k];
            cnt++;
         end
      end
      r.lost = (cnt == 0);
      if (cnt != 0) err = (pos * 2048) / cnt;
      else err = (err_prev > 0) ? LOST_ERR : -LOST_ERR;
      sum = longint'(err_sum) + err;
      if (sum > INT_TOP) begin
         sum = INT_TOP;
         sat_hits++;
      end
      if (sum < INT_BOTTOM) sum = INT_BOTTOM;
      err_sum = int'(sum);
      corr = prop_k * err + integ_k * err_sum + deriv_k * (err - err_prev);
      base = base_lvl <<< Q_SHIFT;
      r.left = drive_level(base + corr);
      r.right = drive_level(base - corr);
      err_prev = err;
      return r;
   endfunction

   function automatic scan_type mark_line(input logic [SENSOR_COUNT-1:0] mask,
                                          input int dark, input int light);
      scan_type s;
      int       k;
      for (k = 0; k < SENSOR_COUNT; k++)
         s[k] = mask[k] ? SAMPLE_BITS'(dark) : SAMPLE_BITS'(light);
      return s;
   endfunction

   // a reading on the requested side of the threshold, often right at it
   function automatic logic [SAMPLE_BITS-1:0] reading(input bit dark);
      if (dark) begin
         if ($urandom_range(0, 3) == 0) return SAMPLE_BITS'(dark_level);
         return SAMPLE_BITS'($urandom_range(SAMPLE_TOP, dark_level));
      end
      if (dark_level == 0) return '0;
      if ($urandom_range(0, 3) == 0) return SAMPLE_BITS'(dark_level - 1);
      return SAMPLE_BITS'($urandom_range(dark_level - 1, 0));
   endfunction

   function automatic scan_type random_scan();
      scan_type s;
      int       kind;
      int       width;
      int       first;
      int       k;
      kind = $urandom_range(0, 19);
      width = $urandom_range(1, 3);
      first = $urandom_range(0, SENSOR_COUNT - width);
      for (k = 0; k < SENSOR_COUNT; k++) begin
         if (kind < 5) s[k] = SAMPLE_BITS'($urandom);
         else if (kind < 7) s[k] = reading(1'b0);
         else if (kind == 7) s[k] = reading(1'b1);
         else s[k] = reading(k >= first && k < first + width);
      end
      return s;
   endfunction

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            steer_expect.push_back(predict_steer(held_scan));
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() != 0) begin
               held_scan = pending.pop_front();
               offer = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_valid <= offer;
            if (offer) begin
               req_sample_far_left   <= held_scan[0];
               req_sample_near_left  <= held_scan[1];
               req_sample_center     <= held_scan[2];
               req_sample_near_right <= held_scan[3];
               req_sample_far_right  <= held_scan[4];
            end
         end
      end
   end

   function automatic void flag_field(input string name, input int want, input int got);
      bad++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
   endfunction

   function automatic void check_steer();
      steer_type want;
      if (steer_expect.size() == 0) begin
         bad++;
         $error("steering result with no item outstanding");
         return;
      end
      want = steer_expect.pop_front();
      results_checked++;
      if (rsp_left_speed !== want.left)
         flag_field("left_speed", want.left, rsp_left_speed);
      if (rsp_right_speed !== want.right)
         flag_field("right_speed", want.right, rsp_right_speed);
      if (rsp_line_lost !== want.lost)
         flag_field("line_lost", want.lost, rsp_line_lost);
   endfunction

   // receiver: stall pattern of its own plus long hold-offs
   always @(posedge clock) begin
      bit hold;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_steer();
         rsp_cycle++;
         if (rsp_cycle % 64 == 0) stall_mode = flow_type'($urandom_range(0, 3));
         if (hold_left == 0) begin
            if (!held_once && results_checked >= 150) begin
               held_once = 1'b1;
               hold_left = LONG_HOLD;
            end else if ($urandom_range(0, 2999) == 0) begin
               hold_left = $urandom_range(50, LONG_HOLD);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            hold = 1'b1;
         end else begin
            case (stall_mode)
               FLOW_FREE:   hold = 1'b0;
               FLOW_COIN:   hold = 1'($urandom_range(0, 1));
               FLOW_CHOKED: hold = ($urandom_range(0, 3) != 0);
               default:     hold = ((rsp_cycle / 3) % 2) == 1;
            endcase
         end
         rsp_stall <= hold;
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [GAIN_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      cfg_apply(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic write_set(input logic [GAIN_BITS-1:0] p, input logic [GAIN_BITS-1:0] i,
                            input logic [GAIN_BITS-1:0] d, input logic [GAIN_BITS-1:0] b,
                            input logic [GAIN_BITS-1:0] t);
      csr_write(CSR_PROP_GAIN, p);
      csr_write(CSR_INTEG_GAIN, i);
      csr_write(CSR_DERIV_GAIN, d);
      csr_write(CSR_BASE_SPEED, b);
      csr_write(CSR_DARK_THRESHOLD, t);
      settings_used++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending.size() != 0 || req_valid || steer_expect.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int     ph;
      int     k;
      prop_k = longint'(PROP_GAIN_RESET);
      integ_k = longint'(INTEG_GAIN_RESET);
      deriv_k = longint'(DERIV_GAIN_RESET);
      base_lvl = longint'(BASE_SPEED_RESET);
      dark_level = int'(DARK_THRESHOLD_RESET);
      err_prev = 0;
      err_sum = 0;
      settings_used = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed scans under the reset settings
      pending.push_back(mark_line(5'b00000, SAMPLE_TOP, 0));
      pending.push_back(mark_line(5'b11111, SAMPLE_TOP, 0));
      for (k = 0; k < SENSOR_COUNT; k++)
         pending.push_back(mark_line(SENSOR_COUNT'(1 << k), SAMPLE_TOP, 0));
      pending.push_back(mark_line(5'b00000, 0, dark_level - 1));
      pending.push_back(mark_line(5'b00001, SAMPLE_TOP, 0));
      pending.push_back(mark_line(5'b00000, SAMPLE_TOP, 0));
      pending.push_back(mark_line(5'b00000, SAMPLE_TOP, dark_level - 1));
      pending.push_back(mark_line(5'b00011, dark_level, dark_level - 1));
      pending.push_back(mark_line(5'b00111, dark_level, dark_level - 1));
      pending.push_back(mark_line(5'b11100, SAMPLE_TOP, 0));
      pending.push_back(mark_line(5'b01111, dark_level, 0));
      pending.push_back(mark_line(5'b11110, SAMPLE_TOP, dark_level - 1));
      pending.push_back(mark_line(5'b10101, dark_level, 0));
      pending.push_back(mark_line(5'b10001, SAMPLE_TOP, 0));
      pending.push_back(mark_line(5'b11011, dark_level, dark_level - 1));
      pending.push_back(mark_line(5'b01110, SAMPLE_TOP, 0));
      pending.push_back(mark_line(5'b00101, dark_level, 0));
      pending.push_back(mark_line(5'b01001, SAMPLE_TOP, dark_level - 1));
      pending.push_back(mark_line(5'b11001, dark_level, 0));
      wait_idle();

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph == 1) begin
            write_set('1, '1, '1, '1, '1);
            for (k = int'(CSR_DARK_THRESHOLD) + 1; k < (1 << CSR_INDEX_BITS); k++)
               csr_write(CSR_INDEX_BITS'(k), GAIN_BITS'($urandom));
         end else if (ph == 2) begin
            write_set('0, '0, '0, '0, '0);
         end else if (ph > 2) begin
            write_set(GAIN_BITS'($urandom >> (8 + $urandom_range(0, 16))),
                      GAIN_BITS'($urandom >> (8 + $urandom_range(0, 16))),
                      GAIN_BITS'($urandom >> (8 + $urandom_range(0, 16))),
                      GAIN_BITS'($urandom), GAIN_BITS'($urandom));
         end
         for (k = 0; k < ITEMS_PER_SET; k++) pending.push_back(random_scan());
         wait_idle();
      end

      write_set(GAIN_BITS'($urandom_range(0, 24'h0FFFFF)), GAIN_BITS'($urandom_range(0, 16)),
                GAIN_BITS'($urandom_range(0, 24'h0FFFFF)), GAIN_BITS'($urandom),
                GAIN_BITS'($urandom));
      for (k = 0; k < TAIL_ITEMS; k++) pending.push_back(random_scan());
      wait_idle();

      $display("covered %0d scans under %0d register settings, %0d results checked",
               items_sent, settings_used, results_checked);
      $display("integral clamp reached on %0d scans, %0d mismatches", sat_hits, bad);
      if (bad == 0 && steer_expect.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("timeout with %0d results outstanding", steer_expect.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
